@@ rtl/gsd_pkg.sv @@
// Shared types and codes of the GNSS sentence deframer.
package gsd_pkg;

	localparam int unsigned BYTE_W = 8;
	localparam int unsigned LEN_W  = 16;

	// result kinds
	localparam logic [1:0] KIND_PAYLOAD = 2'd0;
	localparam logic [1:0] KIND_TEXT    = 2'd1;
	localparam logic [1:0] KIND_END     = 2'd2;

	// frame end status codes
	localparam logic [2:0] STAT_BIN_OK    = 3'd0;
	localparam logic [2:0] STAT_CSUM_BAD  = 3'd1;
	localparam logic [2:0] STAT_SYNC2_BAD = 3'd2;
	localparam logic [2:0] STAT_TOO_LONG  = 3'd3;
	localparam logic [2:0] STAT_TEXT_OK   = 3'd4;
	localparam logic [2:0] STAT_TEXT_OVF  = 3'd5;
	localparam logic [2:0] STAT_UNSUPP    = 3'd6;
	localparam logic [2:0] STAT_TIMEOUT   = 3'd7;

	// special characters
	localparam logic [7:0] CH_START = 8'h24;
	localparam logic [7:0] CH_OTHER = 8'hD3;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;

	// register indexes on the configuration port
	localparam logic [1:0] REG_SYNC_FIRST  = 2'd0;
	localparam logic [1:0] REG_SYNC_SECOND = 2'd1;
	localparam logic [1:0] REG_BIN_MAX     = 2'd2;
	localparam logic [1:0] REG_TEXT_MAX    = 2'd3;

	localparam int unsigned TDATA_W = 48;

	typedef struct packed {
		logic [7:0]  sync_first;
		logic [7:0]  sync_second;
		logic [15:0] bin_max;
		logic [7:0]  text_max;
	} cfg_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  out_byte;
		logic [7:0]  msg_class;
		logic [7:0]  msg_id;
		logic [15:0] frame_length;
		logic [2:0]  frame_status;
		logic        frame_last;
	} result_t;

endpackage

@@ rtl/gsd_front.sv @@
// Front end of the deframer: accepts bytes, runs the frame parser, builds result records.
module gsd_front (
	input  logic             clk,
	input  logic             arst_n,
	input  gsd_pkg::cfg_t    cfg,
	input  logic             in_valid,
	input  logic [7:0]       in_byte,
	input  logic             in_tmo,
	input  logic             queue_full,
	output logic             in_ready,
	output logic             push,
	output gsd_pkg::result_t rec
);

	localparam logic [3:0] ST_IDLE    = 4'd0;
	localparam logic [3:0] ST_SYNC2   = 4'd1;
	localparam logic [3:0] ST_CLASS   = 4'd2;
	localparam logic [3:0] ST_ID      = 4'd3;
	localparam logic [3:0] ST_LEN_LO  = 4'd4;
	localparam logic [3:0] ST_LEN_HI  = 4'd5;
	localparam logic [3:0] ST_PAYLOAD = 4'd6;
	localparam logic [3:0] ST_CK_A    = 4'd7;
	localparam logic [3:0] ST_CK_B    = 4'd8;
	localparam logic [3:0] ST_TEXT    = 4'd9;

	logic [3:0]  state_q, state_d;
	logic [7:0]  class_q, class_d;
	logic [7:0]  id_q, id_d;
	logic [15:0] len_q, len_d;
	logic [15:0] count_q, count_d;
	logic [7:0]  sum_a_q, sum_a_d;
	logic [7:0]  sum_b_q, sum_b_d;
	logic [7:0]  rx_a_q, rx_a_d;
	logic        cr_q, cr_d;

	logic        fire;
	logic        active;
	logic [7:0]  sa_add;
	logic [7:0]  sb_add;
	logic [15:0] count_inc;
	logic [15:0] len_hi;
	logic        text_end;

	assign in_ready  = !queue_full;
	assign fire      = in_valid && in_ready;
	assign active    = (state_q >= ST_SYNC2) && (state_q <= ST_TEXT);
	assign sa_add    = sum_a_q + in_byte;
	assign sb_add    = sum_b_q + sa_add;
	assign count_inc = count_q + 16'd1;
	assign len_hi    = {in_byte, len_q[7:0]};
	assign text_end  = cr_q && (in_byte == gsd_pkg::CH_LF);

	always_comb begin
		state_d = state_q;
		class_d = class_q;
		id_d    = id_q;
		len_d   = len_q;
		count_d = count_q;
		sum_a_d = sum_a_q;
		sum_b_d = sum_b_q;
		rx_a_d  = rx_a_q;
		cr_d    = cr_q;
		push    = 1'b0;
		rec     = '0;
		if (in_tmo) begin
			state_d = ST_IDLE;
			if (active) begin
				push              = 1'b1;
				rec.kind          = gsd_pkg::KIND_END;
				rec.frame_length  = (state_q == ST_TEXT) ? count_q : len_q;
				rec.frame_status  = gsd_pkg::STAT_TIMEOUT;
				rec.frame_last    = 1'b1;
			end
		end else begin
			unique case (state_q)
				ST_SYNC2: begin
					if (in_byte != cfg.sync_second) begin
						state_d          = ST_IDLE;
						push             = 1'b1;
						rec.kind         = gsd_pkg::KIND_END;
						rec.frame_length = len_q;
						rec.frame_status = gsd_pkg::STAT_SYNC2_BAD;
						rec.frame_last   = 1'b1;
					end else begin
						state_d = ST_CLASS;
					end
				end
				ST_CLASS: begin
					class_d = in_byte;
					sum_a_d = sa_add;
					sum_b_d = sb_add;
					state_d = ST_ID;
				end
				ST_ID: begin
					id_d    = in_byte;
					sum_a_d = sa_add;
					sum_b_d = sb_add;
					state_d = ST_LEN_LO;
				end
				ST_LEN_LO: begin
					len_d   = {8'd0, in_byte};
					sum_a_d = sa_add;
					sum_b_d = sb_add;
					state_d = ST_LEN_HI;
				end
				ST_LEN_HI: begin
					len_d   = len_hi;
					sum_a_d = sa_add;
					sum_b_d = sb_add;
					if (len_hi > cfg.bin_max) begin
						state_d          = ST_IDLE;
						push             = 1'b1;
						rec.kind         = gsd_pkg::KIND_END;
						rec.frame_length = len_hi;
						rec.frame_status = gsd_pkg::STAT_TOO_LONG;
						rec.frame_last   = 1'b1;
					end else begin
						state_d = (len_hi == 16'd0) ? ST_CK_A : ST_PAYLOAD;
					end
				end
				ST_PAYLOAD: begin
					sum_a_d          = sa_add;
					sum_b_d          = sb_add;
					count_d          = count_inc;
					if (count_inc >= len_q) begin
						state_d = ST_CK_A;
					end
					push             = 1'b1;
					rec.kind         = gsd_pkg::KIND_PAYLOAD;
					rec.out_byte     = in_byte;
					rec.frame_length = len_q;
				end
				ST_CK_A: begin
					rx_a_d  = in_byte;
					state_d = ST_CK_B;
				end
				ST_CK_B: begin
					state_d          = ST_IDLE;
					push             = 1'b1;
					rec.kind         = gsd_pkg::KIND_END;
					rec.frame_length = len_q;
					rec.frame_status = ((rx_a_q == sum_a_q) && (in_byte == sum_b_q)) ?
						gsd_pkg::STAT_BIN_OK : gsd_pkg::STAT_CSUM_BAD;
					rec.frame_last   = 1'b1;
				end
				ST_TEXT: begin
					count_d          = count_inc;
					cr_d             = (in_byte == gsd_pkg::CH_CR);
					push             = 1'b1;
					rec.frame_length = count_inc;
					if (text_end) begin
						state_d          = ST_IDLE;
						rec.kind         = gsd_pkg::KIND_END;
						rec.frame_status = gsd_pkg::STAT_TEXT_OK;
						rec.frame_last   = 1'b1;
					end else if (count_inc >= {8'd0, cfg.text_max}) begin
						state_d          = ST_IDLE;
						rec.kind         = gsd_pkg::KIND_END;
						rec.frame_status = gsd_pkg::STAT_TEXT_OVF;
						rec.frame_last   = 1'b1;
					end else begin
						rec.kind     = gsd_pkg::KIND_TEXT;
						rec.out_byte = in_byte;
					end
				end
				default: begin
					// idle and unused codes: clear the frame context, classify the start byte
					state_d = ST_IDLE;
					class_d = '0;
					id_d    = '0;
					len_d   = '0;
					count_d = '0;
					sum_a_d = '0;
					sum_b_d = '0;
					rx_a_d  = '0;
					cr_d    = 1'b0;
					if (in_byte == cfg.sync_first) begin
						state_d = ST_SYNC2;
					end else if (in_byte == gsd_pkg::CH_START) begin
						state_d          = ST_TEXT;
						count_d          = 16'd1;
						push             = 1'b1;
						rec.kind         = gsd_pkg::KIND_TEXT;
						rec.out_byte     = in_byte;
						rec.frame_length = 16'd1;
					end else if (in_byte == gsd_pkg::CH_OTHER) begin
						push             = 1'b1;
						rec.kind         = gsd_pkg::KIND_END;
						rec.frame_status = gsd_pkg::STAT_UNSUPP;
						rec.frame_last   = 1'b1;
					end
				end
			endcase
		end
		rec.msg_class = class_d;
		rec.msg_id    = id_d;
		push          = push && fire;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			class_q <= '0;
			id_q    <= '0;
			len_q   <= '0;
			count_q <= '0;
			sum_a_q <= '0;
			sum_b_q <= '0;
			rx_a_q  <= '0;
			cr_q    <= 1'b0;
		end else if (fire) begin
			state_q <= state_d;
			class_q <= class_d;
			id_q    <= id_d;
			len_q   <= len_d;
			count_q <= count_d;
			sum_a_q <= sum_a_d;
			sum_b_q <= sum_b_d;
			rx_a_q  <= rx_a_d;
			cr_q    <= cr_d;
		end
	end

	a_end_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(push && rec.frame_last) |=> (state_q == ST_IDLE))
		else $error("frame end did not return parser to idle");

	a_payload_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PAYLOAD) |-> (count_q < len_q))
		else $error("payload count reached declared length inside payload");

	a_text_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_TEXT) |-> (count_q != 16'd0))
		else $error("text sentence without start character count");

endmodule

@@ rtl/gsd_fifo.sv @@
// Short result queue between the parser and the output stage.
module gsd_fifo #(
	parameter int unsigned DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  gsd_pkg::result_t push_data,
	input  logic             pop,
	output gsd_pkg::result_t pop_data,
	output logic             full,
	output logic             empty
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	gsd_pkg::result_t  mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;

	assign full     = (count_q == CNT_FULL);
	assign empty    = (count_q == '0);
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

@@ rtl/gsd_back.sv @@
// Output stage: pops result records and holds them on the master stream.
module gsd_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        q_empty,
	input  gsd_pkg::result_t            q_data,
	output logic                        q_pop,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [gsd_pkg::TDATA_W-1:0] m_tdata,
	output logic [1:0]                  m_tuser,
	output logic                        m_tlast
);

	logic             valid_q;
	gsd_pkg::result_t out_q;

	assign q_pop = !q_empty && (!valid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (!valid_q || m_tready) begin
			valid_q <= !q_empty;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			out_q <= q_data;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = {5'd0, out_q.frame_status, out_q.frame_length, out_q.msg_id,
		out_q.msg_class, out_q.out_byte};
	assign m_tuser  = out_q.kind;
	assign m_tlast  = out_q.frame_last;

endmodule

@@ rtl/gnss_sentence_deframer.sv @@
// Top level of the GNSS sentence deframer: register port, parser, result queue, output stage.
// Throughput: one byte per cycle while the queue has room; every accepted byte makes zero or one result.
// A result reaches the master stream by way of the result queue, which the byte's transfer writes,
// and the output register, which loads it from the queue once that register is free or its record is taken.
// The queue holds QUEUE_DEPTH records; s_tready drops only while it is full.
// Reset (arst_n low) returns the parser to idle, empties the queue and loads register defaults.
module gnss_sentence_deframer #(
	parameter int unsigned QUEUE_DEPTH = 4
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// input byte stream
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [7:0]                  s_tdata,  // [7:0] data_byte
	input  logic [0:0]                  s_tuser,  // [0] gap_timeout
	// result stream
	output logic                        m_tvalid,
	input  logic                        m_tready,
	// [7:0] out_byte, [15:8] message_class, [23:16] message_id,
	// [39:24] frame_length, [42:40] frame_status, [47:43] zero
	output logic [gsd_pkg::TDATA_W-1:0] m_tdata,
	output logic [1:0]                  m_tuser,  // [1:0] result_kind
	output logic                        m_tlast,  // frame_last
	// register port
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [3:0]                  paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);

	gsd_pkg::cfg_t    cfg_q;
	logic             cfg_wr;
	logic             q_full;
	logic             q_empty;
	logic             q_push;
	logic             q_pop;
	gsd_pkg::result_t q_in;
	gsd_pkg::result_t q_out;

	// Register file: sync bytes and length limits. Write on the access cycle.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sync_first  <= 8'd181;
			cfg_q.sync_second <= 8'd98;
			cfg_q.bin_max     <= 16'd128;
			cfg_q.text_max    <= 8'd128;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				gsd_pkg::REG_SYNC_FIRST:  cfg_q.sync_first  <= pwdata[7:0];
				gsd_pkg::REG_SYNC_SECOND: cfg_q.sync_second <= pwdata[7:0];
				gsd_pkg::REG_BIN_MAX:     cfg_q.bin_max     <= pwdata[15:0];
				gsd_pkg::REG_TEXT_MAX:    cfg_q.text_max    <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	// Read back the addressed register, zero extended.
	always_comb begin
		unique case (paddr[3:2])
			gsd_pkg::REG_SYNC_FIRST:  prdata = {24'd0, cfg_q.sync_first};
			gsd_pkg::REG_SYNC_SECOND: prdata = {24'd0, cfg_q.sync_second};
			gsd_pkg::REG_BIN_MAX:     prdata = {16'd0, cfg_q.bin_max};
			gsd_pkg::REG_TEXT_MAX:    prdata = {24'd0, cfg_q.text_max};
			default:                  prdata = '0;
		endcase
	end

	// Front: take a byte whenever the queue has room, advance the parser,
	// push the record that the byte causes.
	gsd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.in_valid   (s_tvalid),
		.in_byte    (s_tdata),
		.in_tmo     (s_tuser[0]),
		.queue_full (q_full),
		.in_ready   (s_tready),
		.push       (q_push),
		.rec        (q_in)
	);

	// Queue: decouple the parser from output back-pressure.
	gsd_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_in),
		.pop       (q_pop),
		.pop_data  (q_out),
		.full      (q_full),
		.empty     (q_empty)
	);

	// Back: hold each record in the output register until its transfer.
	gsd_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_empty  (q_empty),
		.q_data   (q_out),
		.q_pop    (q_pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule

@@ tb/gnss_sentence_deframer_tb.sv @@
// Self-checking testbench for the GNSS sentence deframer: byte stream in, parsed results out.
module gnss_sentence_deframer_tb;

	localparam int QUIET_LIMIT = 3000;  // cycles without any transfer before giving up
	localparam int HOLD_CYCLES = 400;   // long result-side hold-off to back up the input
	localparam int DRAIN_CYCLES = 8;    // settle time after the last byte and the last result

	typedef struct packed {
		logic [7:0] data;
		logic       tmo;
	} rx_item_t;

	typedef enum logic [3:0] {
		P_IDLE, P_SYNC2, P_CLASS, P_ID, P_LEN_LO, P_LEN_HI, P_PAYLOAD, P_CK_A, P_CK_B, P_TEXT
	} parse_e;

	typedef enum {B_GOOD, B_SYNC2, B_CKA, B_CKB, B_LONG, B_CUT} bin_flaw_e;
	typedef enum {T_OK, T_OVF, T_CUT} text_flaw_e;

	logic                        clk = 1'b0;
	logic                        arst_n = 1'b0;
	logic                        s_tvalid = 1'b0;
	logic                        s_tready;
	logic [7:0]                  s_tdata = '0;   // [7:0] data_byte
	logic [0:0]                  s_tuser = '0;   // [0] gap_timeout
	logic                        m_tvalid;
	logic                        m_tready = 1'b0;
	// [7:0] out_byte, [15:8] message_class, [23:16] message_id,
	// [39:24] frame_length, [42:40] frame_status, [47:43] zero
	logic [gsd_pkg::TDATA_W-1:0] m_tdata;
	logic [1:0]                  m_tuser;        // [1:0] result_kind
	logic                        m_tlast;        // frame_last
	logic                        psel = 1'b0;
	logic                        penable = 1'b0;
	logic                        pwrite = 1'b0;
	logic [3:0]                  paddr = '0;
	logic [31:0]                 pwdata = '0;
	logic [31:0]                 prdata;
	logic                        pready;

	gnss_sentence_deframer u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// bytes waiting to go out, and results the parser owes us
	rx_item_t          pending_bytes[$];
	gsd_pkg::result_t  due_results[$];
	int                mismatches = 0;
	int                send_idle_pct = 0;
	int                recv_idle_pct = 0;
	logic              pressure_req = 1'b0;

	// shadow of the parser: registers and per-frame state
	gsd_pkg::cfg_t cfg_q = '{sync_first: 8'd181, sync_second: 8'd98,
		bin_max: 16'd128, text_max: 8'd128};
	parse_e        ps = P_IDLE;
	logic [7:0]    cls_q = '0;
	logic [7:0]    id_q = '0;
	logic [15:0]   dlen = '0;
	logic [15:0]   cnt = '0;
	logic [7:0]    sa = '0;
	logic [7:0]    sb = '0;
	logic [7:0]    rsa = '0;
	logic          cr_seen = 1'b0;

	function automatic void check_field(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			mismatches++;
		end
	endfunction

	// Advance the shadow parser by one transferred byte and queue the result it owes.
	function automatic void deframe_byte(input logic [7:0] b, input logic tmo);
		logic             fire;
		logic [1:0]       kind;
		logic [7:0]       obyte;
		logic [15:0]      flen;
		logic [2:0]       stat;
		logic             line_end;
		gsd_pkg::result_t r;
		fire = 1'b0;
		kind = gsd_pkg::KIND_END;
		obyte = '0;
		flen = '0;
		stat = gsd_pkg::STAT_BIN_OK;
		if (tmo) begin
			// a gap only ends a frame that is open
			if (ps != P_IDLE) begin
				fire = 1'b1;
				stat = gsd_pkg::STAT_TIMEOUT;
				flen = (ps == P_TEXT) ? cnt : dlen;
			end
			ps = P_IDLE;
		end else begin
			// Fletcher covers class, id, both length bytes and the payload
			if (ps >= P_CLASS && ps <= P_PAYLOAD) begin
				sa += b;
				sb += sa;
			end
			case (ps)
				P_SYNC2: begin
					if (b == cfg_q.sync_second) begin
						ps = P_CLASS;
					end else begin
						fire = 1'b1;
						stat = gsd_pkg::STAT_SYNC2_BAD;
						flen = dlen;
					end
				end
				P_CLASS: begin
					cls_q = b;
					ps = P_ID;
				end
				P_ID: begin
					id_q = b;
					ps = P_LEN_LO;
				end
				P_LEN_LO: begin
					dlen = {8'h00, b};
					ps = P_LEN_HI;
				end
				P_LEN_HI: begin
					dlen[15:8] = b;
					if (dlen > cfg_q.bin_max) begin
						fire = 1'b1;
						stat = gsd_pkg::STAT_TOO_LONG;
						flen = dlen;
					end else begin
						ps = (dlen == 16'd0) ? P_CK_A : P_PAYLOAD;
					end
				end
				P_PAYLOAD: begin
					cnt++;
					if (cnt >= dlen) ps = P_CK_A;
					fire = 1'b1;
					kind = gsd_pkg::KIND_PAYLOAD;
					obyte = b;
					flen = dlen;
				end
				P_CK_A: begin
					rsa = b;
					ps = P_CK_B;
				end
				P_CK_B: begin
					fire = 1'b1;
					stat = (rsa == sa && b == sb) ? gsd_pkg::STAT_BIN_OK : gsd_pkg::STAT_CSUM_BAD;
					flen = dlen;
				end
				P_TEXT: begin
					line_end = cr_seen && b == gsd_pkg::CH_LF;
					cnt++;
					cr_seen = (b == gsd_pkg::CH_CR);
					fire = 1'b1;
					flen = cnt;
					// CR LF wins over the length limit
					if (line_end) begin
						stat = gsd_pkg::STAT_TEXT_OK;
					end else if (cnt >= {8'h00, cfg_q.text_max}) begin
						stat = gsd_pkg::STAT_TEXT_OVF;
					end else begin
						kind = gsd_pkg::KIND_TEXT;
						obyte = b;
					end
				end
				default: begin
					// idle: every byte clears the frame state, then the start byte is classified
					cls_q = '0;
					id_q = '0;
					dlen = '0;
					cnt = '0;
					sa = '0;
					sb = '0;
					rsa = '0;
					cr_seen = 1'b0;
					ps = P_IDLE;
					if (b == cfg_q.sync_first) begin
						ps = P_SYNC2;
					end else if (b == gsd_pkg::CH_START) begin
						ps = P_TEXT;
						cnt = 16'd1;
						fire = 1'b1;
						kind = gsd_pkg::KIND_TEXT;
						obyte = b;
						flen = cnt;
					end else if (b == gsd_pkg::CH_OTHER) begin
						fire = 1'b1;
						stat = gsd_pkg::STAT_UNSUPP;
					end
				end
			endcase
		end
		if (fire) begin
			if (kind == gsd_pkg::KIND_END) ps = P_IDLE;
			r.kind = kind;
			r.out_byte = obyte;
			r.msg_class = cls_q;
			r.msg_id = id_q;
			r.frame_length = flen;
			r.frame_status = (kind == gsd_pkg::KIND_END) ? stat : gsd_pkg::STAT_BIN_OK;
			r.frame_last = (kind == gsd_pkg::KIND_END);
			due_results.push_back(r);
		end
	endfunction

	// Sender: offer queued bytes, idling at random; predict each byte on its transfer.
	always @(posedge clk) begin : send_bytes
		rx_item_t it;
		if (arst_n) begin
			if (s_tvalid && s_tready) deframe_byte(s_tdata, s_tuser[0]);
			if (!s_tvalid || s_tready) begin
				if (pending_bytes.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					it = pending_bytes.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= it.data;
					s_tuser <= it.tmo;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Receiver: check each result transfer against the oldest owed result, then pick
	// the next ready. A pressure request holds ready low for a long stretch.
	always @(posedge clk) begin : take_results
		gsd_pkg::result_t want;
		int               hold_left;
		logic             pressure_seen;
		if (!arst_n) begin
			hold_left = 0;
			pressure_seen = 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (due_results.size() == 0) begin
					$error("unexpected result: kind %0d tdata 0x%0h last %0b",
						m_tuser, m_tdata, m_tlast);
					mismatches++;
				end else begin
					want = due_results.pop_front();
					check_field("result_kind", want.kind, m_tuser);
					check_field("out_byte", want.out_byte, m_tdata[7:0]);
					check_field("message_class", want.msg_class, m_tdata[15:8]);
					check_field("message_id", want.msg_id, m_tdata[23:16]);
					check_field("frame_length", want.frame_length, m_tdata[39:24]);
					check_field("frame_status", want.frame_status, m_tdata[42:40]);
					check_field("frame_last", want.frame_last, m_tlast);
				end
			end
			if (pressure_req && !pressure_seen) begin
				pressure_seen = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left != 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
			end
		end
	end

	// Watchdog: any transfer on either stream or the register port counts as progress.
	always @(posedge clk) begin : watchdog
		int quiet;
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) begin
			quiet = 0;
		end else begin
			quiet++;
			if (quiet >= QUIET_LIMIT) begin
				$display("gnss_sentence_deframer_tb: FAIL");
				$finish;
			end
		end
	end

	task automatic push_item(input logic [7:0] data, input logic tmo);
		rx_item_t it;
		it.data = data;
		it.tmo = tmo;
		pending_bytes.push_back(it);
	endtask

	// Write a register through setup and access cycles, then read it back.
	task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		// write lands on this edge; turn straight into the read setup
		case (idx)
			gsd_pkg::REG_SYNC_FIRST:  cfg_q.sync_first = val[7:0];
			gsd_pkg::REG_SYNC_SECOND: cfg_q.sync_second = val[7:0];
			gsd_pkg::REG_BIN_MAX:     cfg_q.bin_max = val[15:0];
			default:                  cfg_q.text_max = val[7:0];
		endcase
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		check_field("prdata", val, prdata);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	function automatic logic [7:0] text_char();
		if ($urandom_range(0, 11) == 0) return gsd_pkg::CH_CR;
		return 8'($urandom_range(32, 126));
	endfunction

	// Queue a binary frame; a flaw breaks it in one chosen way.
	task automatic push_binary(input bin_flaw_e flaw, input logic [7:0] cls, input logic [7:0] id,
		input logic [15:0] len);
		logic [7:0] frame[$];
		logic [7:0] fa;
		logic [7:0] fb;
		logic [7:0] flip;
		int         npay;
		int         cut;
		flip = 8'($urandom_range(1, 255));
		frame.push_back(cfg_q.sync_first);
		if (flaw == B_SYNC2) begin
			frame.push_back(cfg_q.sync_second ^ flip);
		end else begin
			frame.push_back(cfg_q.sync_second);
			frame.push_back(cls);
			frame.push_back(id);
			frame.push_back(len[7:0]);
			frame.push_back(len[15:8]);
			// a cut frame never needs its whole payload
			npay = (flaw == B_LONG) ? 0 : (flaw == B_CUT && len > 8) ? 8 : int'(len);
			repeat (npay) frame.push_back(8'($urandom_range(0, 255)));
			fa = '0;
			fb = '0;
			for (int i = 2; i < frame.size(); i++) begin
				fa += frame[i];
				fb += fa;
			end
			if (flaw == B_CKA) fa ^= flip;
			if (flaw == B_CKB) fb ^= flip;
			if (flaw == B_GOOD || flaw == B_CKA || flaw == B_CKB) begin
				frame.push_back(fa);
				frame.push_back(fb);
			end
		end
		cut = (flaw == B_CUT) ? $urandom_range(1, frame.size()) : frame.size();
		for (int i = 0; i < cut; i++) push_item(frame[i], 1'b0);
		if (flaw == B_CUT) push_item(8'($urandom_range(0, 255)), 1'b1);
	endtask

	// Queue a text sentence; lengths stay clear of the limit unless overflow is wanted.
	task automatic push_text(input text_flaw_e flaw);
		int span;
		int cap;
		push_item(gsd_pkg::CH_START, 1'b0);
		case (flaw)
			T_OVF: begin
				span = int'(cfg_q.text_max) - 1;
			end
			T_CUT: begin
				cap = int'(cfg_q.text_max) - 2;
				span = $urandom_range(0, cap > 10 ? 10 : cap);
			end
			default: begin
				cap = int'(cfg_q.text_max) - 3;
				span = ($urandom_range(0, 19) == 0) ? cap : $urandom_range(0, cap > 20 ? 20 : cap);
			end
		endcase
		repeat (span) push_item(text_char(), 1'b0);
		if (flaw == T_OK) begin
			push_item(gsd_pkg::CH_CR, 1'b0);
			push_item(gsd_pkg::CH_LF, 1'b0);
		end else if (flaw == T_CUT) begin
			push_item(8'($urandom_range(0, 255)), 1'b1);
		end
	endtask

	// Short directed run under the first setting (wide limits).
	task automatic push_directed();
		push_item(8'hFF, 1'b1);                 // gap while idle: nothing
		push_item(8'h00, 1'b0);                 // unknown idle byte: dropped
		push_item(gsd_pkg::CH_OTHER, 1'b0);     // unsupported frame marker
		push_binary(B_GOOD, 8'hFF, 8'h00, 16'h0000);  // empty payload
		push_item(cfg_q.sync_first, 1'b0);      // bad second sync, not re-examined
		push_item(cfg_q.sync_first, 1'b0);
		push_item(gsd_pkg::CH_START, 1'b0);     // shortest sentence
		push_item(gsd_pkg::CH_CR, 1'b0);
		push_item(gsd_pkg::CH_LF, 1'b0);
		// largest declared length, cut short by a gap
		push_item(cfg_q.sync_first, 1'b0);
		push_item(cfg_q.sync_second, 1'b0);
		push_item(8'h01, 1'b0);
		push_item(8'h02, 1'b0);
		push_item(8'hFF, 1'b0);
		push_item(8'hFF, 1'b0);
		push_item(8'hFF, 1'b0);
		push_item(8'h00, 1'b0);
		push_item(8'h00, 1'b1);
		push_item(gsd_pkg::CH_START, 1'b0);     // sentence ended by a gap
		push_item(8'h41, 1'b0);
		push_item(8'h00, 1'b1);
	endtask

	// Mostly well-formed frames with random content, the rest broken frames and noise.
	task automatic push_random(input int n);
		int          made;
		int          mark;
		int          pick;
		logic [15:0] bm;
		logic [15:0] len;
		logic [7:0]  junk;
		made = 0;
		bm = cfg_q.bin_max;
		while (made < n) begin
			mark = pending_bytes.size();
			pick = $urandom_range(0, 99);
			len = ($urandom_range(0, 24) == 0 && bm <= 300) ? bm :
				16'($urandom_range(0, bm > 24 ? 24 : bm));
			if (pick < 40) begin
				push_binary(B_GOOD, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), len);
			end else if (pick < 60) begin
				push_text(T_OK);
			end else if (pick < 64) begin
				push_binary(B_SYNC2, 8'h00, 8'h00, 16'h0000);
			end else if (pick < 68) begin
				push_binary(B_CKA, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), len);
			end else if (pick < 72) begin
				push_binary(B_CKB, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), len);
			end else if (pick < 81) begin
				// too long needs room above the limit; otherwise cut the frame
				if (pick < 76 && bm != 16'hFFFF) begin
					len = $urandom_range(0, 1) ? bm + 16'd1 :
						16'($urandom_range(int'(bm) + 1, 65535));
					push_binary(B_LONG, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
						len);
				end else begin
					push_binary(B_CUT, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
						len);
				end
			end else if (pick < 84) begin
				push_text(T_OVF);
			end else if (pick < 87) begin
				push_text(T_CUT);
			end else if (pick < 90) begin
				push_item(gsd_pkg::CH_OTHER, 1'b0);
			end else if (pick < 94) begin
				// raw junk may open frames anywhere; a gap usually resyncs
				repeat ($urandom_range(1, 4)) push_item(8'($urandom_range(0, 255)), 1'b0);
				if ($urandom_range(0, 1)) push_item(8'($urandom_range(0, 255)), 1'b1);
			end else if (pick < 97) begin
				do junk = 8'($urandom_range(0, 255));
				while (junk == cfg_q.sync_first || junk == gsd_pkg::CH_START ||
					junk == gsd_pkg::CH_OTHER);
				push_item(junk, 1'b0);
			end else begin
				push_item(8'($urandom_range(0, 255)), 1'b1);
			end
			// ignored idle bytes and idle gaps do not count toward the run
			if (pick < 94) made += pending_bytes.size() - mark;
		end
	endtask

	// Hold until every byte is through and every result is in, then let the pipe settle.
	task automatic drain();
		do @(negedge clk);
		while (pending_bytes.size() != 0 || s_tvalid || due_results.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic run_setting(input logic [7:0] sf, input logic [7:0] ss, input logic [15:0] bm,
		input logic [7:0] tm, input int n, input int mode, input bit directed);
		case (mode)
			0: begin
				send_idle_pct = 35;
				recv_idle_pct = 65;
			end
			1: begin
				send_idle_pct = 65;
				recv_idle_pct = 35;
			end
			default: begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
		endcase
		reg_write(gsd_pkg::REG_SYNC_FIRST, {24'h0, sf});
		reg_write(gsd_pkg::REG_SYNC_SECOND, {24'h0, ss});
		reg_write(gsd_pkg::REG_BIN_MAX, {16'h0, bm});
		reg_write(gsd_pkg::REG_TEXT_MAX, {24'h0, tm});
		if (directed) push_directed();
		push_random(n);
		// with the sender never idle, a long hold backs the parser up into its input
		if (mode == 2) pressure_req = 1'b1;
		drain();
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		run_setting(8'hB5, 8'h62, 16'hFFFF, 8'd255, 350, 0, 1'b1);
		// smallest limits: every non-empty binary frame is too long
		run_setting(8'h00, 8'hFF, 16'h0000, 8'd3, 250, 0, 1'b0);
		// sync_first equal to '$' takes priority over text
		run_setting(gsd_pkg::CH_START, gsd_pkg::CH_OTHER, 16'd30, 8'd40, 100, 1, 1'b0);
		run_setting(8'hFF, 8'h00, 16'd64, 8'd20, 300, 1, 1'b0);
		// sync_first equal to 0xD3 takes priority over the unsupported marker
		run_setting(gsd_pkg::CH_OTHER, gsd_pkg::CH_START, 16'd200, 8'd128, 400, 2, 1'b0);
		repeat (20) @(posedge clk);
		if (mismatches == 0 && due_results.size() == 0) begin
			$display("gnss_sentence_deframer_tb: PASS");
		end else begin
			$display("gnss_sentence_deframer_tb: FAIL");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/gsd_pkg.sv
rtl/gsd_front.sv
rtl/gsd_fifo.sv
rtl/gsd_back.sv
rtl/gnss_sentence_deframer.sv
tb/gnss_sentence_deframer_tb.sv
